/* sv/sdf_pkg.sv */
// Shared types and constants for the stream duplicate filter.
// No dependencies; imported by sdf_cell and stream_duplicate_filter_core.
package sdf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 64;

    // Beat travelling along the compare chain
    typedef struct packed {
        logic                      vld;
        logic                      hit;
        logic signed [VALUE_W-1:0] value;
    } t_token;

endpackage

/* sv/sdf_cell.sv */
// One compare cell of the seen-value chain: holds a single table entry.
// Depends on sdf_pkg (t_token).
module sdf_cell
    import sdf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic signed [VALUE_W-1:0] r_entry;
    t_token                    r_tok;
    t_token                    n_tok;
    logic                      in_range;
    logic                      hit_here;
    logic                      store;

    always_comb begin
        in_range  = CNT_W'(INDEX) < i_count;
        hit_here  = in_range && (r_entry == i_tok.value);
        store     = i_tok.vld && !i_tok.hit && (CNT_W'(INDEX) == i_count);
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit || hit_here;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.hit   <= n_tok.hit;
        r_tok.value <= n_tok.value;
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_entry <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/stream_duplicate_filter_core.sv */
// Stream duplicate filter: passes the first occurrence of each 64-bit value within a set,
// in arrival order; a start-of-set beat empties the table first. Each beat walks a chain
// of DEPTH compare cells, one cell per cycle, and the fill count is updated when it leaves
// the chain, so one beat is in flight at a time: a new beat is accepted once a duplicate
// has left the chain or a passed value has moved to the output register. A result may
// wait at the output without blocking the next input beat. When the table is full a new
// value is passed with overflow set and is not stored. Depends on sdf_pkg and sdf_cell.
module stream_duplicate_filter_core
    import sdf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_start_of_set,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_value_out,
    output logic                      o_overflow
);

    t_token                    tok [DEPTH+1];
    t_token                    r_in_tok;
    logic [CNT_W-1:0]          r_fill;
    logic                      r_busy;
    logic                      r_pend_vld;
    logic signed [VALUE_W-1:0] r_pend_value;
    logic                      r_pend_ovf;
    logic                      r_out_vld;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_ovf;
    logic                      accept;
    logic                      exit_beat;
    logic                      table_full;
    logic                      out_free;

    assign o_ready    = !r_busy;
    assign accept     = i_valid && o_ready;
    assign exit_beat  = tok[DEPTH].vld;
    assign table_full = (r_fill == CNT_W'(DEPTH));
    assign out_free   = !r_out_vld || i_ready;

    assign tok[0] = r_in_tok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sdf_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_fill),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok.vld <= 1'b0;
            r_fill       <= '0;
            r_busy       <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_in_tok.vld <= accept;
            if (accept) begin
                r_busy <= 1'b1;
                if (i_start_of_set) begin
                    r_fill <= '0;
                end
            end
            if (exit_beat) begin
                if (tok[DEPTH].hit) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pend_vld <= 1'b1;
                    if (!table_full) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                end
            end
            if (r_pend_vld && out_free) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
                r_busy     <= 1'b0;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_in_tok.hit   <= 1'b0;
        r_in_tok.value <= i_value;
    end

    always_ff @(posedge i_clk) begin
        if (exit_beat) begin
            r_pend_value <= tok[DEPTH].value;
            r_pend_ovf   <= table_full;
        end
        if (r_pend_vld && out_free) begin
            r_out_value <= r_pend_value;
            r_out_ovf   <= r_pend_ovf;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_value_out = r_out_value;
    assign o_overflow  = r_out_ovf;

`ifndef SYNTHESIS
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exit_beat |-> r_busy)
        else $error("beat left the chain with no beat in flight");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && r_in_tok.vld)
        else $error("accepted beat did not enter the chain");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld && r_pend_ovf) |-> table_full)
        else $error("overflow flagged with room in the table");
`endif

endmodule
